/* design/catmull_rom_spline_evaluator_assert.svh */
// Assertion macros shared by the Catmull-Rom spline evaluator modules.
`ifndef CATMULL_ROM_SPLINE_EVALUATOR_ASSERT_SVH
`define CATMULL_ROM_SPLINE_EVALUATOR_ASSERT_SVH

// The condition must never hold outside reset.
`define CRS_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define CRS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CRS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/crs_pkg.sv */
// Types, constants and weight function of the Catmull-Rom spline evaluator.
package crs_pkg;

   localparam int COORD_W    = 16;
   localparam int GRAD_W     = 20;
   localparam int PIDX_W     = 4;
   localparam int PARAM_W    = 16;
   // The point count must be a power of two; looped indices wrap by masking.
   localparam int NUM_POINTS = 16;
   localparam int FRAC_BITS  = 12;

   localparam int SEG_W     = PARAM_W - FRAC_BITS;
   localparam int IDX_W     = $clog2(NUM_POINTS);
   localparam int IDX_MAX_W = (SEG_W > IDX_W) ? SEG_W : IDX_W;
   localparam int IDXF_W    = ((IDX_MAX_W > PIDX_W) ? IDX_MAX_W : PIDX_W) + 2;
   localparam int TAP_W     = 2;

   localparam int W_W     = FRAC_BITS + 3;
   localparam int G_W     = 2 * FRAC_BITS + 3;
   localparam int QP_W    = 3 * FRAC_BITS + 5;
   localparam int QG_W    = 2 * FRAC_BITS + 6;
   localparam int PP_W    = COORD_W + W_W;
   localparam int PG_W    = COORD_W + G_W;
   localparam int ACC_P_W = PP_W + 2;
   localparam int ACC_G_W = PG_W + 2;

   localparam logic [TAP_W-1:0] TAP_PREV  = 2'd0;
   localparam logic [TAP_W-1:0] TAP_START = 2'd1;
   localparam logic [TAP_W-1:0] TAP_END   = 2'd2;
   localparam logic [TAP_W-1:0] TAP_NEXT  = 2'd3;
   localparam logic [TAP_W-1:0] DRAIN_LAST = 2'd1;

   localparam logic signed [QP_W-1:0] CUBE_ONE = QP_W'(longint'(1) <<< (3 * FRAC_BITS));
   localparam logic signed [QP_W-1:0] HALF_P   = QP_W'(longint'(1) <<< (2 * FRAC_BITS - 1));
   localparam logic signed [QG_W-1:0] SQ_ONE   = QG_W'(longint'(1) <<< (2 * FRAC_BITS));

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_EVAL  = 1'b1
   } crs_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_CUBE,
      ST_STEP,
      ST_DRAIN,
      ST_DONE
   } crs_state_type;

   typedef struct packed {
      crs_op_type                 operation;
      logic [PIDX_W-1:0]          point_index;
      logic signed [COORD_W-1:0]  point_x;
      logic signed [COORD_W-1:0]  point_y;
      logic [PARAM_W-1:0]         curve_param;
   } crs_req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0]  pos_x;
      logic signed [COORD_W-1:0]  pos_y;
      logic signed [GRAD_W-1:0]   grad_x;
      logic signed [GRAD_W-1:0]   grad_y;
      logic                       out_of_range;
      logic                       clipped;
   } crs_rsp_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
   } crs_point_type;

   typedef struct packed {
      logic               wr_en;
      logic [IDX_W-1:0]   wr_addr;
      crs_point_type      wr_point;
      logic               rd_en;
      logic [IDX_W-1:0]   rd_addr;
   } crs_mem_req_type;

   typedef struct packed {
      logic                  square;
      logic                  cube;
      logic                  step;
      logic [TAP_W-1:0]      step_tap;
      logic [FRAC_BITS-1:0]  frac;
   } crs_mac_ctl_type;

   typedef struct packed {
      logic load;
      logic write_item;
      logic out_of_range;
   } crs_done_type;

   typedef struct packed {
      logic signed [W_W-1:0] pos_w;
      logic signed [G_W-1:0] grad_w;
   } crs_weight_type;

   // Doubled position weight rounded to units of 1/F and exact doubled gradient weight in units of 1/F^2.
   function automatic crs_weight_type crs_weights(
      input logic [TAP_W-1:0]         tap,
      input logic [FRAC_BITS-1:0]     f,
      input logic [2*FRAC_BITS-1:0]   f2,
      input logic [3*FRAC_BITS-1:0]   f3
   );
      logic signed [QP_W-1:0] t3;
      logic signed [QP_W-1:0] t2f;
      logic signed [QP_W-1:0] t1ff;
      logic signed [QP_W-1:0] qp;
      logic signed [QG_W-1:0] t2;
      logic signed [QG_W-1:0] t1f;
      logic signed [QG_W-1:0] qg;
      crs_weight_type         w;
      t3   = QP_W'(signed'({1'b0, f3}));
      t2f  = QP_W'(signed'({1'b0, f2})) <<< FRAC_BITS;
      t1ff = QP_W'(signed'({1'b0, f})) <<< (2 * FRAC_BITS);
      t2   = QG_W'(signed'({1'b0, f2}));
      t1f  = QG_W'(signed'({1'b0, f})) <<< FRAC_BITS;
      case (tap)
         TAP_PREV: begin
            qp = -t3 + (t2f <<< 1) - t1ff + HALF_P;
            qg = -(t2 <<< 1) - t2 + (t1f <<< 2) - SQ_ONE;
         end
         TAP_START: begin
            qp = (t3 <<< 1) + t3 - (t2f <<< 2) - t2f + (CUBE_ONE <<< 1) + HALF_P;
            qg = (t2 <<< 3) + t2 - (t1f <<< 3) - (t1f <<< 1);
         end
         TAP_END: begin
            qp = -(t3 <<< 1) - t3 + (t2f <<< 2) + t1ff + HALF_P;
            qg = -(t2 <<< 3) - t2 + (t1f <<< 3) + SQ_ONE;
         end
         TAP_NEXT: begin
            qp = t3 - t2f + HALF_P;
            qg = (t2 <<< 1) + t2 - (t1f <<< 1);
         end
         default: begin
            qp = '0;
            qg = '0;
         end
      endcase
      w.pos_w  = qp[2*FRAC_BITS +: W_W];
      w.grad_w = qg[G_W-1:0];
      return w;
   endfunction

endpackage

/* design/crs_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
module crs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]          wr_data,
   input  logic                      rd_en,
   input  logic [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/crs_point_store.sv */
// Control point memory with per-entry valid bits so unwritten points read as zero.
module crs_point_store (
   input  logic                     clock,
   input  logic                     reset,
   input  crs_pkg::crs_mem_req_type mem,
   output crs_pkg::crs_point_type   rd_point
);

   logic [crs_pkg::NUM_POINTS-1:0] valid_ff;
   logic [crs_pkg::NUM_POINTS-1:0] valid_in;
   logic                           rd_hit_ff;
   logic                           rd_hit_in;
   logic [2*crs_pkg::COORD_W-1:0]  ram_q;

   crs_ram #(
      .WIDTH(2 * crs_pkg::COORD_W),
      .DEPTH(crs_pkg::NUM_POINTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem.wr_en),
      .wr_addr (mem.wr_addr),
      .wr_data (mem.wr_point),
      .rd_en   (mem.rd_en),
      .rd_addr (mem.rd_addr),
      .rd_data (ram_q)
   );

   always_comb begin
      valid_in = valid_ff;
      if (mem.wr_en) begin
         valid_in[mem.wr_addr] = 1'b1;
      end
      rd_hit_in = mem.rd_en && valid_ff[mem.rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_hit_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         rd_hit_ff <= rd_hit_in;
      end
   end

   assign rd_point = rd_hit_ff ? crs_pkg::crs_point_type'(ram_q) : '0;

endmodule

/* design/crs_mac.sv */
// Weight generation, multiply-accumulate, rounding and saturation datapath.
module crs_mac (
   input  logic                     clock,
   input  logic                     reset,
   input  crs_pkg::crs_mac_ctl_type ctl,
   input  crs_pkg::crs_point_type   point,
   output crs_pkg::crs_rsp_type     calc
);

   localparam int FB = crs_pkg::FRAC_BITS;
   localparam int AP = crs_pkg::ACC_P_W;
   localparam int AG = crs_pkg::ACC_G_W;
   localparam int CW = crs_pkg::COORD_W;
   localparam int GW = crs_pkg::GRAD_W;

   localparam logic signed [AP-1:0] RND_P  = AP'(longint'(1) <<< FB);
   localparam logic signed [AG-1:0] RND_G  = AG'(longint'(1) <<< (2 * FB));
   localparam logic signed [AP-1:0] POS_HI = AP'((longint'(1) <<< (CW - 1)) - 1);
   localparam logic signed [AP-1:0] POS_LO = AP'(-(longint'(1) <<< (CW - 1)));
   localparam logic signed [AG-1:0] GRD_HI = AG'((longint'(1) <<< (GW - 1)) - 1);
   localparam logic signed [AG-1:0] GRD_LO = AG'(-(longint'(1) <<< (GW - 1)));

   logic [2*FB-1:0]                      f2_ff, f2_in;
   logic [3*FB-1:0]                      f3_ff, f3_in;
   crs_pkg::crs_weight_type              wt_ff, wt_in;
   logic                                 s1_ff, s2_ff;
   logic signed [crs_pkg::PP_W-1:0]      ppx_ff, ppy_ff, ppx_in, ppy_in;
   logic signed [crs_pkg::PG_W-1:0]      pgx_ff, pgy_ff, pgx_in, pgy_in;
   logic signed [AP-1:0]                 apx_ff, apy_ff, apx_in, apy_in;
   logic signed [AG-1:0]                 agx_ff, agy_ff, agx_in, agy_in;
   logic signed [AP-1:0]                 rpx, rpy;
   logic signed [AG-1:0]                 rgx, rgy;
   logic [CW:0]                          spx, spy;
   logic [GW:0]                          sgx, sgy;

   function automatic logic [CW:0] sat_pos(input logic signed [AP-1:0] v);
      logic [CW:0] r;
      if (v > POS_HI) begin
         r = {1'b1, POS_HI[CW-1:0]};
      end else if (v < POS_LO) begin
         r = {1'b1, POS_LO[CW-1:0]};
      end else begin
         r = {1'b0, v[CW-1:0]};
      end
      return r;
   endfunction

   function automatic logic [GW:0] sat_grad(input logic signed [AG-1:0] v);
      logic [GW:0] r;
      if (v > GRD_HI) begin
         r = {1'b1, GRD_HI[GW-1:0]};
      end else if (v < GRD_LO) begin
         r = {1'b1, GRD_LO[GW-1:0]};
      end else begin
         r = {1'b0, v[GW-1:0]};
      end
      return r;
   endfunction

   always_comb begin
      f2_in = f2_ff;
      if (ctl.square) begin
         f2_in = (2*FB)'(ctl.frac) * (2*FB)'(ctl.frac);
      end
      f3_in = f3_ff;
      if (ctl.cube) begin
         f3_in = (3*FB)'(f2_ff) * (3*FB)'(ctl.frac);
      end
      wt_in = wt_ff;
      if (ctl.step) begin
         wt_in = crs_pkg::crs_weights(ctl.step_tap, ctl.frac, f2_ff, f3_ff);
      end
      ppx_in = crs_pkg::PP_W'(point.x) * crs_pkg::PP_W'(wt_ff.pos_w);
      ppy_in = crs_pkg::PP_W'(point.y) * crs_pkg::PP_W'(wt_ff.pos_w);
      pgx_in = crs_pkg::PG_W'(point.x) * crs_pkg::PG_W'(wt_ff.grad_w);
      pgy_in = crs_pkg::PG_W'(point.y) * crs_pkg::PG_W'(wt_ff.grad_w);
      apx_in = apx_ff;
      apy_in = apy_ff;
      agx_in = agx_ff;
      agy_in = agy_ff;
      if (ctl.cube) begin
         apx_in = '0;
         apy_in = '0;
         agx_in = '0;
         agy_in = '0;
      end else if (s2_ff) begin
         apx_in = apx_ff + AP'(ppx_ff);
         apy_in = apy_ff + AP'(ppy_ff);
         agx_in = agx_ff + AG'(pgx_ff);
         agy_in = agy_ff + AG'(pgy_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= 1'b0;
         s2_ff <= 1'b0;
      end else begin
         s1_ff <= ctl.step;
         s2_ff <= s1_ff;
      end
   end

   always_ff @(posedge clock) begin
      f2_ff  <= f2_in;
      f3_ff  <= f3_in;
      wt_ff  <= wt_in;
      ppx_ff <= ppx_in;
      ppy_ff <= ppy_in;
      pgx_ff <= pgx_in;
      pgy_ff <= pgy_in;
      apx_ff <= apx_in;
      apy_ff <= apy_in;
      agx_ff <= agx_in;
      agy_ff <= agy_in;
   end

   always_comb begin
      rpx = (apx_ff + RND_P) >>> (FB + 1);
      rpy = (apy_ff + RND_P) >>> (FB + 1);
      rgx = (agx_ff + RND_G) >>> (2 * FB + 1);
      rgy = (agy_ff + RND_G) >>> (2 * FB + 1);
      spx = sat_pos(rpx);
      spy = sat_pos(rpy);
      sgx = sat_grad(rgx);
      sgy = sat_grad(rgy);
      calc.pos_x        = spx[CW-1:0];
      calc.pos_y        = spy[CW-1:0];
      calc.grad_x       = sgx[GW-1:0];
      calc.grad_y       = sgy[GW-1:0];
      calc.out_of_range = 1'b0;
      calc.clipped      = spx[CW] | spy[CW] | sgx[GW] | sgy[GW];
   end

endmodule

/* design/crs_ctrl.sv */
// Sequencer that writes points, walks the four point reads and schedules the datapath.
`include "catmull_rom_spline_evaluator_assert.svh"

module crs_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  crs_pkg::crs_req_type     req_item,
   input  logic                     loop_mode,
   input  logic                     rsp_free,
   output crs_pkg::crs_mem_req_type mem,
   output crs_pkg::crs_mac_ctl_type ctl,
   output crs_pkg::crs_done_type    done
);

   localparam int XW = crs_pkg::IDXF_W;

   crs_pkg::crs_state_type            state_ff, state_in;
   logic [crs_pkg::TAP_W-1:0]         tap_ff, tap_in;
   logic [crs_pkg::FRAC_BITS-1:0]     frac_ff, frac_in;
   logic [crs_pkg::SEG_W-1:0]         seg_ff, seg_in;
   logic                              wr_item_ff, wr_item_in;
   logic                              oor_ff, oor_in;
   logic [XW-1:0]                     open_idx;
   logic [XW-1:0]                     loop_idx;
   logic [XW-1:0]                     slot_idx;
   logic                              in_table;

   assign req_stall = (state_ff != crs_pkg::ST_IDLE);

   always_comb begin
      open_idx = XW'(seg_ff) + XW'(tap_ff);
      loop_idx = XW'(seg_ff) + XW'(tap_ff) + XW'(crs_pkg::NUM_POINTS - 1);
      slot_idx = XW'(req_item.point_index);
      in_table = loop_mode || (open_idx < XW'(crs_pkg::NUM_POINTS));
   end

   always_comb begin
      state_in   = state_ff;
      tap_in     = tap_ff;
      frac_in    = frac_ff;
      seg_in     = seg_ff;
      wr_item_in = wr_item_ff;
      oor_in     = oor_ff;
      mem        = '0;
      mem.wr_addr  = slot_idx[crs_pkg::IDX_W-1:0];
      mem.wr_point.x = req_item.point_x;
      mem.wr_point.y = req_item.point_y;
      mem.rd_addr  = loop_mode ? loop_idx[crs_pkg::IDX_W-1:0]
                               : open_idx[crs_pkg::IDX_W-1:0];
      ctl          = '0;
      ctl.frac     = frac_ff;
      ctl.step_tap = tap_ff;
      done         = '0;
      done.write_item   = wr_item_ff;
      done.out_of_range = oor_ff;
      case (state_ff)
         crs_pkg::ST_IDLE: begin
            if (req_valid) begin
               oor_in = 1'b0;
               if (req_item.operation == crs_pkg::OP_WRITE) begin
                  mem.wr_en  = (slot_idx < XW'(crs_pkg::NUM_POINTS));
                  wr_item_in = 1'b1;
                  state_in   = crs_pkg::ST_DONE;
               end else begin
                  frac_in    = req_item.curve_param[crs_pkg::FRAC_BITS-1:0];
                  seg_in     = req_item.curve_param[crs_pkg::PARAM_W-1:crs_pkg::FRAC_BITS];
                  wr_item_in = 1'b0;
                  state_in   = crs_pkg::ST_SQUARE;
               end
            end
         end
         crs_pkg::ST_SQUARE: begin
            ctl.square = 1'b1;
            state_in   = crs_pkg::ST_CUBE;
         end
         crs_pkg::ST_CUBE: begin
            ctl.cube = 1'b1;
            tap_in   = crs_pkg::TAP_PREV;
            state_in = crs_pkg::ST_STEP;
         end
         crs_pkg::ST_STEP: begin
            ctl.step   = 1'b1;
            mem.rd_en  = in_table;
            oor_in     = oor_ff || !in_table;
            tap_in     = tap_ff + crs_pkg::TAP_W'(1);
            if (tap_ff == crs_pkg::TAP_NEXT) begin
               state_in = crs_pkg::ST_DRAIN;
            end
         end
         crs_pkg::ST_DRAIN: begin
            tap_in = tap_ff + crs_pkg::TAP_W'(1);
            if (tap_ff == crs_pkg::DRAIN_LAST) begin
               state_in = crs_pkg::ST_DONE;
            end
         end
         crs_pkg::ST_DONE: begin
            done.load = rsp_free;
            if (rsp_free) begin
               state_in = crs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = crs_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= crs_pkg::ST_IDLE;
         tap_ff   <= '0;
      end else begin
         state_ff <= state_in;
         tap_ff   <= tap_in;
      end
   end

   always_ff @(posedge clock) begin
      frac_ff    <= frac_in;
      seg_ff     <= seg_in;
      wr_item_ff <= wr_item_in;
      oor_ff     <= oor_in;
   end

   `CRS_ASSERT_NEVER(a_write_only_idle, clock, reset, mem.wr_en && (state_ff != crs_pkg::ST_IDLE), "point write outside idle")
   `CRS_ASSERT_IMPLY(a_read_only_step, clock, reset, mem.rd_en, state_ff == crs_pkg::ST_STEP, "point read outside step phase")
   `CRS_ASSERT_NEXT(a_last_tap_drains, clock, reset, (state_ff == crs_pkg::ST_STEP) && (tap_ff == crs_pkg::TAP_NEXT), state_ff == crs_pkg::ST_DRAIN, "fourth read not followed by drain")

endmodule

/* design/catmull_rom_spline_evaluator.sv */
// Top level of the Catmull-Rom spline evaluator: mode register, core blocks and result register.
// A write transfer stores one control point and returns an all-zero result through the done
// state. An evaluate transfer passes from acceptance to a loaded result through the square and
// cube states, which form f squared and f cubed in the weight multiplier, the step state, which
// reads the four neighboring points in turn through the single read port of the point memory,
// the drain state, which empties the multiply-accumulate pipeline, and the done state, which
// loads the result register. A new transfer is taken only in the idle state, so evaluations do
// not overlap. The next transfer is taken while a finished result waits in the output register;
// its own result then waits in its last cycle until the output register is free. Points never
// written read as zero; no clearing pass is needed after reset.
`include "catmull_rom_spline_evaluator_assert.svh"

module catmull_rom_spline_evaluator (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  crs_pkg::crs_req_type  req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output crs_pkg::crs_rsp_type  rsp_item,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_data
);

   logic                     loop_mode_ff, loop_mode_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   crs_pkg::crs_rsp_type     rsp_ff, rsp_in;
   logic                     rsp_free;
   crs_pkg::crs_mem_req_type mem;
   crs_pkg::crs_mac_ctl_type ctl;
   crs_pkg::crs_done_type    done;
   crs_pkg::crs_point_type   rd_point;
   crs_pkg::crs_rsp_type     calc;

   assign csr_ready = 1'b1;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   crs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .loop_mode (loop_mode_ff),
      .rsp_free  (rsp_free),
      .mem       (mem),
      .ctl       (ctl),
      .done      (done)
   );

   crs_point_store u_store (
      .clock    (clock),
      .reset    (reset),
      .mem      (mem),
      .rd_point (rd_point)
   );

   crs_mac u_mac (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .point (rd_point),
      .calc  (calc)
   );

   always_comb begin
      loop_mode_in = loop_mode_ff;
      if (csr_valid && csr_ready) begin
         loop_mode_in = csr_data;
      end
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if (done.load) begin
         rsp_valid_in = 1'b1;
         if (done.write_item) begin
            rsp_in = '0;
         end else begin
            rsp_in              = calc;
            rsp_in.out_of_range = done.out_of_range;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loop_mode_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         loop_mode_ff <= loop_mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   `CRS_ASSERT_IMPLY(a_oor_open_only, clock, reset, rsp_valid_ff && rsp_ff.out_of_range, !loop_mode_ff, "out of range flagged in looped mode")

endmodule
